### design/chs_pkg.sv
// chs_pkg: shared constants, request/result types and store control struct
// for the chained key hash set; no dependencies
package chs_pkg;

  localparam int BUCKETS     = 64;
  localparam int CHAIN_DEPTH = 8;
  localparam int KEY_W       = 32;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int SLOT_W   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int FILL_W   = $clog2(CHAIN_DEPTH + 1);
  localparam int KEY_AW   = BUCKET_W + SLOT_W;
  localparam int KEY_DEPTH = BUCKETS * (2 ** SLOT_W);

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CHAIN_DEPTH);

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_CONTAINS = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic hit;
    logic bucket_full;
  } res_t;

  // sequencer to store: read addresses and write strobes
  typedef struct packed {
    logic [KEY_AW-1:0]   key_raddr;
    logic                key_we;
    logic [KEY_AW-1:0]   key_waddr;
    logic [KEY_W-1:0]    key_wdata;
    logic [BUCKET_W-1:0] fill_raddr;
    logic                fill_we;
    logic [BUCKET_W-1:0] fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
  } store_ctl_t;

endpackage

### design/chained_key_hash_set.sv
// chained_key_hash_set: top level, request/result handshakes and the scan
// sequencer; depends on chs_pkg and chs_store
//
// A set of 32-bit keys in BUCKETS buckets of up to CHAIN_DEPTH keys each;
// the bucket is the low bits of the key. Each request carries a command
// (insert, contains, remove) and a key, and gives exactly one result with
// hit and bucket_full. One request is in work at a time and req_stall is
// high while it is. A request reads the fill count of its bucket (the keys
// held in it), compares stored keys from slot 0 up and then loads the
// result register; the result appears in the same cycle that req_stall
// drops. A contains or a duplicate insert that matches at slot p ends its
// scan there. A remove that hits at slot p makes p + 1 compares, then moves
// each later key down one slot and then updates the fill count. The single
// read port of the key memory sets the pace: one stored key is compared per
// cycle, and during a remove one key is moved per cycle. The result sits
// in an output register, so a new request is taken while an earlier result
// still waits on res_stall. Of the storage, reset clears only the fill
// count valid bits (one per bucket), so every bucket reads as empty; there
// is no clearing pass and the set is usable at once.
module chained_key_hash_set (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  chs_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output chs_pkg::res_t res_data
);
  import chs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t            state;
  logic [1:0]        cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] idx;
  logic              hit_q;
  logic              full_q;

  store_ctl_t        ctl;
  logic [KEY_W-1:0]  key_rdata;
  logic [FILL_W-1:0] fill_rdata;

  logic [BUCKET_W-1:0] bucket_q;
  logic [FILL_W:0]     idx_p1;
  logic [FILL_W:0]     idx_p2;
  logic                at_end;
  logic                key_match;
  logic                shift_more;

  assign bucket_q   = key_q[BUCKET_W-1:0];
  assign idx_p1     = {1'b0, idx} + 1'b1;
  assign idx_p2     = {1'b0, idx} + 2'd2;
  assign at_end     = (idx == fill_q);
  assign key_match  = (key_rdata == key_q);
  // another key above the current slot still has to move down
  assign shift_more = (idx_p1 < {1'b0, fill_q});

  assign req_stall = (state != S_IDLE);

  chs_store u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .key_rdata  (key_rdata),
    .fill_rdata (fill_rdata)
  );

  // store addressing and writes
  always_comb begin
    ctl = '0;
    // fill read goes out with the request itself
    ctl.fill_raddr = (state == S_IDLE) ? req_data.key[BUCKET_W-1:0] : bucket_q;
    ctl.fill_waddr = bucket_q;
    ctl.key_wdata  = key_q;
    ctl.key_waddr  = {bucket_q, idx[SLOT_W-1:0]};
    unique case (state)
      S_FILL: begin
        ctl.key_raddr = {bucket_q, SLOT_W'(0)};
      end
      S_SCAN: begin
        // look-ahead read: next slot to compare, or first key to move down
        ctl.key_raddr = {bucket_q, idx_p1[SLOT_W-1:0]};
        if (at_end && cmd_q == CMD_INSERT && fill_q < FILL_MAX) begin
          ctl.key_we     = 1'b1;
          ctl.fill_we    = 1'b1;
          ctl.fill_wdata = fill_q + 1'b1;
        end
      end
      S_SHIFT: begin
        ctl.key_raddr = {bucket_q, idx_p2[SLOT_W-1:0]};
        if (shift_more) begin
          ctl.key_we    = 1'b1;
          ctl.key_wdata = key_rdata;
        end else begin
          ctl.fill_we    = 1'b1;
          ctl.fill_wdata = fill_q - 1'b1;
        end
      end
      default: begin
        ctl.key_raddr = {bucket_q, idx[SLOT_W-1:0]};
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // the finish state loads the result register itself
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q  <= req_data.cmd;
            key_q  <= req_data.key;
            hit_q  <= 1'b0;
            full_q <= 1'b0;
            state  <= S_FILL;
          end
        end
        S_FILL: begin
          fill_q <= fill_rdata;
          idx    <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (at_end) begin
            // key absent from the bucket
            if (cmd_q == CMD_INSERT) begin
              if (fill_q < FILL_MAX) begin
                hit_q <= 1'b1;
              end else begin
                full_q <= 1'b1;
              end
            end
            state <= S_FINISH;
          end else if (key_match) begin
            if (cmd_q == CMD_CONTAINS) begin
              hit_q <= 1'b1;
              state <= S_FINISH;
            end else if (cmd_q == CMD_REMOVE) begin
              hit_q <= 1'b1;
              state <= S_SHIFT;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            idx <= idx_p1[FILL_W-1:0];
          end
        end
        S_SHIFT: begin
          if (shift_more) begin
            idx <= idx_p1[FILL_W-1:0];
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (!res_valid || !res_stall) begin
            res_valid            <= 1'b1;
            res_data.hit         <= hit_q;
            res_data.bucket_full <= full_q;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/chs_store.sv
// chs_store: key memory (one write, one registered read) and per-bucket
// fill counts with valid bits; depends on chs_pkg
module chs_store (
  input  logic                        clk,
  input  logic                        rst,
  input  chs_pkg::store_ctl_t         ctl,
  output logic [chs_pkg::KEY_W-1:0]   key_rdata,
  output logic [chs_pkg::FILL_W-1:0]  fill_rdata
);
  import chs_pkg::*;

  logic [KEY_W-1:0]  key_mem  [KEY_DEPTH];
  logic [FILL_W-1:0] fill_mem [BUCKETS];
  logic [BUCKETS-1:0] fill_vld;
  logic [FILL_W-1:0] fill_q;
  logic              fill_vld_q;

  // key memory, contents undefined until written
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[ctl.key_waddr] <= ctl.key_wdata;
    end
    key_rdata <= key_mem[ctl.key_raddr];
  end

  // fill counts, payload without reset
  always_ff @(posedge clk) begin
    if (ctl.fill_we) begin
      fill_mem[ctl.fill_waddr] <= ctl.fill_wdata;
    end
    fill_q <= fill_mem[ctl.fill_raddr];
  end

  // valid bits: an unwritten bucket reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld   <= '0;
      fill_vld_q <= 1'b0;
    end else begin
      if (ctl.fill_we) begin
        fill_vld[ctl.fill_waddr] <= 1'b1;
      end
      fill_vld_q <= fill_vld[ctl.fill_raddr];
    end
  end

  assign fill_rdata = fill_vld_q ? fill_q : '0;

endmodule

### design/chs_checker.sv
// chs_checker: port-level checks on the chained key hash set, bound to the
// top level; depends on chs_pkg and chained_key_hash_set
module chs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input chs_pkg::req_t req_data,
  input logic          res_valid,
  input logic          res_stall,
  input chs_pkg::res_t res_data
);
  import chs_pkg::*;

  // an accepted request keeps req_stall high in the fill and scan states that follow
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall ##1 req_stall)
    else $error("request taken too soon after a previous request");

  // a refused insert never also reports a hit
  a_hit_full_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.hit && res_data.bucket_full))
    else $error("result shows both hit and bucket_full");

  // no result appears in the cycle right after a request is taken
  a_no_instant_res: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !res_valid) |=> !res_valid)
    else $error("result appeared without time for a scan");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
    else $error("stalled result dropped or changed");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
    else $error("stalled request dropped or changed");

endmodule

bind chained_key_hash_set chs_checker u_chs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

### verif/chained_key_hash_set_tb.sv
// chained_key_hash_set_tb: self-checking bench for the chained key hash set
// drives insert/contains/remove requests, predicts each result, checks them
// depends on chs_pkg and chained_key_hash_set
`timescale 1ns / 1ps

module chained_key_hash_set_tb;
  import chs_pkg::*;

  localparam int TAG_W       = KEY_W - BUCKET_W;
  localparam int STALL_LIMIT = 5000;  // cycles with no request or result moving
  localparam int DRAIN_WAIT  = 2 * CHAIN_DEPTH + 8;
  localparam int PHASE_ITEMS = 425;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  // idling knobs, percent per cycle
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // shadow copy of the set: keys per bucket in slot order, and fill counts
  logic [KEY_W-1:0] shadow_keys [BUCKETS][CHAIN_DEPTH];
  int               shadow_fill [BUCKETS];

  res_t pending_results [$];
  int   fail_count = 0;
  int   quiet_cycles = 0;

  chained_key_hash_set dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #6 clk = ~clk;

  // applies one request to the shadow set and gives the result it must produce
  function automatic res_t apply_to_shadow(req_t r);
    logic [BUCKET_W-1:0] b;
    int   fill;
    int   pos;
    int   i;
    res_t res;
    b    = r.key[BUCKET_W-1:0];  // bucket is the low bits of the key
    fill = shadow_fill[b];
    pos  = fill;
    res  = '0;
    // only slots below the fill count are looked at
    for (i = 0; i < fill; i++)
      if (pos == fill && shadow_keys[b][i] == r.key) pos = i;
    case (cmd_t'(r.cmd))
      CMD_INSERT: begin
        if (pos == fill) begin
          if (fill >= CHAIN_DEPTH) begin
            res.bucket_full = 1'b1;  // refused, bucket already full
          end else begin
            shadow_keys[b][fill] = r.key;
            shadow_fill[b]       = fill + 1;
            res.hit              = 1'b1;
          end
        end
      end
      CMD_CONTAINS: res.hit = (pos < fill);
      CMD_REMOVE: begin
        if (pos < fill) begin
          // later keys move down one slot to close the gap
          for (i = pos; i + 1 < fill; i++) shadow_keys[b][i] = shadow_keys[b][i + 1];
          shadow_fill[b] = fill - 1;
          res.hit        = 1'b1;
        end
      end
      default: ;  // unused code: no change, nothing flagged
    endcase
    return res;
  endfunction

  // sends one request, idling beforehand at the current sender rate;
  // valid stays high on return so back-to-back requests need no re-raise
  task automatic send_request(cmd_t c, logic [KEY_W-1:0] k);
    req_t r;
    r.cmd = c;
    r.key = k;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(apply_to_shadow(r));
  endtask

  // receiver side: random stall, one update per edge
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got hit=%0b bucket_full=%0b",
                 $time, res_data.hit, res_data.bucket_full);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_data.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b",
                   $time, want.hit, res_data.hit);
          fail_count++;
        end
        if (res_data.bucket_full !== want.bucket_full) begin
          $display("%0t: bucket_full mismatch, expected %0b actual %0b",
                   $time, want.bucket_full, res_data.bucket_full);
          fail_count++;
        end
      end
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // fills one bucket to the brim, then one more insert must be refused
  task automatic test_fill_and_overflow();
    int i;
    for (i = 0; i < CHAIN_DEPTH; i++) send_request(CMD_INSERT, KEY_W'((i << BUCKET_W) | 5));
    send_request(CMD_INSERT, KEY_W'((CHAIN_DEPTH << BUCKET_W) | 5));
  endtask

  // duplicate insert is a no-op; lookups hit and miss in a full bucket
  task automatic test_duplicates_and_lookup();
    send_request(CMD_INSERT, KEY_W'(5));
    send_request(CMD_CONTAINS, KEY_W'((3 << BUCKET_W) | 5));
    send_request(CMD_CONTAINS, KEY_W'(((CHAIN_DEPTH + 1) << BUCKET_W) | 5));
  endtask

  // remove from the middle, check the shifted tail and the freed slot
  task automatic test_remove_and_compaction();
    send_request(CMD_REMOVE, KEY_W'((2 << BUCKET_W) | 5));
    send_request(CMD_CONTAINS, KEY_W'(((CHAIN_DEPTH - 1) << BUCKET_W) | 5));
    send_request(CMD_CONTAINS, KEY_W'((2 << BUCKET_W) | 5));
    send_request(CMD_REMOVE, KEY_W'((2 << BUCKET_W) | 5));
    send_request(CMD_INSERT, KEY_W'((CHAIN_DEPTH << BUCKET_W) | 5));
  endtask

  // all-ones and all-zero keys, empty bucket lookup, unused command code
  task automatic test_extremes_and_unused_cmd();
    send_request(CMD_CONTAINS, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_CONTAINS, '1);
    send_request(CMD_UNUSED, '1);
    send_request(CMD_REMOVE, '1);
    send_request(CMD_INSERT, '0);
    send_request(CMD_UNUSED, '0);
  endtask

  // random requests aimed at a few hot buckets with reused tags, so that
  // buckets overflow, duplicates occur and removes find their keys
  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    logic [BUCKET_W-1:0] hot [4];
    logic [TAG_W-1:0]    tags [CHAIN_DEPTH + 4];
    logic [BUCKET_W-1:0] b;
    logic [KEY_W-1:0]    k;
    cmd_t c;
    int   n;
    int   roll;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    foreach (hot[i]) hot[i] = BUCKET_W'($urandom_range(BUCKETS - 1));
    foreach (tags[i]) tags[i] = TAG_W'($urandom);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40)      c = CMD_INSERT;
      else if (roll < 70) c = CMD_CONTAINS;
      else if (roll < 95) c = CMD_REMOVE;
      else                c = CMD_UNUSED;
      if ($urandom_range(9) == 0) begin
        k = $urandom;  // noise: any key at all
      end else begin
        if ($urandom_range(9) < 8) b = hot[$urandom_range(3)];
        else                       b = BUCKET_W'($urandom_range(BUCKETS - 1));
        k = {tags[$urandom_range(CHAIN_DEPTH + 3)], b};
      end
      send_request(c, k);
    end
  endtask

  initial begin
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    foreach (shadow_keys[i, j]) shadow_keys[i][j] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_overflow();
    test_duplicates_and_lookup();
    test_remove_and_compaction();
    test_extremes_and_unused_cmd();

    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(68, 0, PHASE_ITEMS);
    test_random_traffic(0, 68, PHASE_ITEMS);
    test_random_traffic(38, 38, PHASE_ITEMS);

    // last request is already accepted in this step, drop valid and drain
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
